/* sv/srpt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package srpt_pkg;

   localparam int MAX_WAITING_DEFAULT = 32;

   localparam int TIME_W = 40;
   localparam int ACC_W  = 64;

   // one item on the request channel
   typedef struct packed {
      logic        command;
      logic [31:0] arrive_tick;
      logic [19:0] work_ticks;
      logic [15:0] job_id;
   } req_type;

   // one item on the response channel
   typedef struct packed {
      logic        is_summary;
      logic [15:0] done_id;
      logic [39:0] finish_tick;
      logic [39:0] flow_time;
      logic [63:0] flow_sum;
      logic [63:0] flow_square_sum;
      logic [39:0] flow_max;
      logic [31:0] jobs_done;
      logic        overflow;
      logic        last;
   } rsp_type;

   // one entry of the waiting store
   typedef struct packed {
      logic [19:0] remaining;
      logic [31:0] arrival;
      logic [15:0] id;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   localparam logic CMD_ARRIVAL = 1'b0;
   localparam logic CMD_FINISH  = 1'b1;

endpackage

`default_nettype wire

/* sv/srpt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module srpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* sv/srpt_preemptive_scheduler_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// srpt scheduler: slot data in one memory, valid bits in flops.
// each pick scans the whole store through the memory read port in S_SCAN, then S_PICK
// runs the job; a completion passes S_SQR, S_ACC and S_PUSH, and an item is accepted in
// S_IDLE, admitted in S_ADMIT and handed off in S_FLUSH, one item at a time.
// reset clears control, time, accumulators and valid bits; slot memory is not cleared.
module srpt_preemptive_scheduler_top
   import srpt_pkg::*;
#(
   parameter int MAX_WAITING = MAX_WAITING_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   localparam int IW = $clog2(MAX_WAITING);
   localparam int CW = $clog2(MAX_WAITING + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_SCAN  = 8'b0000_0010,
      S_PICK  = 8'b0000_0100,
      S_SQR   = 8'b0000_1000,
      S_ACC   = 8'b0001_0000,
      S_PUSH  = 8'b0010_0000,
      S_ADMIT = 8'b0100_0000,
      S_FLUSH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic found_ff, found_in;
   slot_type best_ff, best_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [MAX_WAITING-1:0] valid_ff, valid_in;
   logic [TIME_W-1:0] ct_ff, ct_in;
   logic [ACC_W-1:0] sum_ff, sum_in;
   logic [ACC_W-1:0] sq_sum_ff, sq_sum_in;
   logic [TIME_W-1:0] max_ff, max_in;
   logic [31:0] jobs_ff, jobs_in;
   logic drop_ff, drop_in;
   logic [TIME_W-1:0] flow_ff, flow_in;
   logic [ACC_W-1:0] sqv_ff, sqv_in;
   rsp_type new_ff, new_in;
   logic final_ff, final_in;
   rsp_type pend_ff, pend_in;
   logic pend_vld_ff, pend_vld_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic wr_en;
   logic [IW-1:0] wr_addr;
   slot_type wr_data;
   logic [IW-1:0] rd_addr;
   slot_type rd_data;

   // slot data store
   srpt_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(MAX_WAITING)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // datapath for one execution step
   logic [IW-1:0] prev_idx;
   logic [TIME_W-1:0] limit40, gap;
   logic [19:0] exec_len, rem_new;
   logic [TIME_W:0] ct_sum;
   logic [TIME_W-1:0] ct_new, flow_new;
   logic [ACC_W:0] sum_wide, sq_wide;
   logic out_free;
   logic drain;
   logic any_free;
   logic [IW-1:0] free_idx;

   assign prev_idx = IW'(cnt_ff - CW'(1));
   assign drain = (req_ff.command == CMD_FINISH);
   assign limit40 = {8'd0, req_ff.arrive_tick};
   assign gap = limit40 - ct_ff;
   assign exec_len = (drain || gap >= {20'd0, best_ff.remaining})
                     ? best_ff.remaining : gap[19:0];
   assign ct_sum = {1'b0, ct_ff} + {21'd0, exec_len};
   assign ct_new = ct_sum[TIME_W] ? '1 : ct_sum[TIME_W-1:0];
   assign rem_new = best_ff.remaining - exec_len;
   assign flow_new = ct_new - {8'd0, best_ff.arrival};
   assign sum_wide = {1'b0, sum_ff} + {25'd0, flow_ff};
   assign sq_wide = {1'b0, sq_sum_ff} + {1'b0, sqv_ff};
   assign out_free = !rsp_valid_ff || rsp_ready;

   // lowest free slot
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = MAX_WAITING - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            any_free = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   // control and next state
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      cnt_in = cnt_ff;
      found_in = found_ff;
      best_in = best_ff;
      best_idx_in = best_idx_ff;
      valid_in = valid_ff;
      ct_in = ct_ff;
      sum_in = sum_ff;
      sq_sum_in = sq_sum_ff;
      max_in = max_ff;
      jobs_in = jobs_ff;
      drop_in = drop_ff;
      flow_in = flow_ff;
      sqv_in = sqv_ff;
      new_in = new_ff;
      final_in = final_ff;
      pend_in = pend_ff;
      pend_vld_in = pend_vld_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en = 1'b0;
      wr_addr = best_idx_ff;
      wr_data = best_ff;
      rd_addr = (cnt_ff == CW'(MAX_WAITING)) ? '0 : cnt_ff[IW-1:0];
      req_ready = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               cnt_in = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         // walk the store, keep the shortest remaining job
         S_SCAN: begin
            if (cnt_ff != '0 && valid_ff[prev_idx] &&
                (!found_ff || rd_data.remaining < best_ff.remaining ||
                 (rd_data.remaining == best_ff.remaining && rd_data.id < best_ff.id))) begin
               found_in = 1'b1;
               best_in = rd_data;
               best_idx_in = prev_idx;
            end
            if (cnt_ff == CW'(MAX_WAITING)) begin
               state_in = S_PICK;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         // run the chosen job up to the arrival tick, then admit; on a finish with none left, emit the summary
         S_PICK: begin
            cnt_in = '0;
            found_in = 1'b0;
            if (!found_ff) begin
               if (drain) begin
                  new_in = '0;
                  new_in.is_summary = 1'b1;
                  new_in.finish_tick = ct_ff;
                  new_in.flow_sum = sum_ff;
                  new_in.flow_square_sum = sq_sum_ff;
                  new_in.flow_max = max_ff;
                  new_in.jobs_done = jobs_ff;
                  new_in.overflow = drop_ff;
                  final_in = 1'b1;
                  ct_in = '0;
                  sum_in = '0;
                  sq_sum_in = '0;
                  max_in = '0;
                  jobs_in = '0;
                  drop_in = 1'b0;
                  state_in = S_PUSH;
               end else begin
                  if (ct_ff < limit40) begin
                     ct_in = limit40;
                  end
                  state_in = S_ADMIT;
               end
            end else if (!drain && ct_ff >= limit40) begin
               state_in = S_ADMIT;
            end else begin
               ct_in = ct_new;
               wr_en = 1'b1;
               wr_data.remaining = rem_new;
               if (rem_new != '0) begin
                  state_in = S_SCAN;
               end else begin
                  valid_in[best_idx_ff] = 1'b0;
                  flow_in = flow_new;
                  state_in = S_SQR;
               end
            end
         end
         // square the flow, update the simple accumulators
         S_SQR: begin
            sqv_in = (flow_ff[39:32] != '0) ? '1
                     : {32'd0, flow_ff[31:0]} * {32'd0, flow_ff[31:0]};
            sum_in = sum_wide[ACC_W] ? '1 : sum_wide[ACC_W-1:0];
            if (flow_ff > max_ff) begin
               max_in = flow_ff;
            end
            if (jobs_ff != '1) begin
               jobs_in = jobs_ff + 32'd1;
            end
            state_in = S_ACC;
         end
         S_ACC: begin
            sq_sum_in = sq_wide[ACC_W] ? '1 : sq_wide[ACC_W-1:0];
            new_in = '0;
            new_in.done_id = best_ff.id;
            new_in.finish_tick = ct_ff;
            new_in.flow_time = flow_ff;
            final_in = 1'b0;
            state_in = S_PUSH;
         end
         // hold one record back so the last one can be marked
         S_PUSH: begin
            if (!pend_vld_ff) begin
               pend_in = new_ff;
               pend_vld_in = 1'b1;
               state_in = final_ff ? S_FLUSH : S_SCAN;
            end else if (out_free) begin
               rsp_in = pend_ff;
               rsp_in.last = 1'b0;
               rsp_valid_in = 1'b1;
               pend_in = new_ff;
               state_in = final_ff ? S_FLUSH : S_SCAN;
            end
         end
         // place the arrival or drop it
         S_ADMIT: begin
            if (req_ff.work_ticks == '0) begin
               state_in = S_FLUSH;
            end else if (any_free) begin
               wr_en = 1'b1;
               wr_addr = free_idx;
               wr_data.remaining = req_ff.work_ticks;
               wr_data.arrival = req_ff.arrive_tick;
               wr_data.id = req_ff.job_id;
               valid_in[free_idx] = 1'b1;
               state_in = S_FLUSH;
            end else begin
               drop_in = 1'b1;
               new_in = '0;
               new_in.done_id = req_ff.job_id;
               new_in.overflow = 1'b1;
               final_in = 1'b1;
               state_in = S_PUSH;
            end
         end
         S_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_in = pend_ff;
               rsp_in.last = 1'b1;
               rsp_valid_in = 1'b1;
               pend_vld_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         ct_ff <= '0;
         sum_ff <= '0;
         sq_sum_ff <= '0;
         max_ff <= '0;
         jobs_ff <= '0;
         drop_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         final_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         ct_ff <= ct_in;
         sum_ff <= sum_in;
         sq_sum_ff <= sq_sum_in;
         max_ff <= max_in;
         jobs_ff <= jobs_in;
         drop_ff <= drop_in;
         pend_vld_ff <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff <= found_in;
         final_ff <= final_in;
         cnt_ff <= cnt_in;
      end
      req_ff <= req_in;
      best_ff <= best_in;
      best_idx_ff <= best_idx_in;
      flow_ff <= flow_in;
      sqv_ff <= sqv_in;
      new_ff <= new_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* test/tb_srpt_preemptive_scheduler_top.sv */
`timescale 1ns / 1ps
`default_nettype none

module tb_srpt_preemptive_scheduler_top;
   import srpt_pkg::*;

   localparam int STORE_N = 32;
   localparam logic [39:0] TICK_MAX = 40'hFF_FFFF_FFFF;
   localparam longint unsigned CYCLE_LIMIT = 3000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   srpt_preemptive_scheduler_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // scheduler shadow state
   logic [39:0] sched_now = '0;
   bit          job_live [STORE_N];
   logic [19:0] job_left [STORE_N];
   logic [31:0] job_arr [STORE_N];
   logic [15:0] job_tag [STORE_N];
   logic [63:0] run_flow_sum = '0;
   logic [63:0] run_flow_sq = '0;
   logic [39:0] run_flow_max = '0;
   logic [31:0] run_jobs = '0;
   bit          run_dropped;

   rsp_type     pending_records [$];
   int          mismatch_count = 0;
   longint unsigned cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_off_cycles = 0;
   logic [31:0] last_arrival = 0;

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic int shortest_job();
      int best;
      best = -1;
      for (int i = 0; i < STORE_N; i++) begin
         if (!job_live[i]) continue;
         if (best < 0 || job_left[i] < job_left[best] ||
             (job_left[i] == job_left[best] && job_tag[i] < job_tag[best]))
            best = i;
      end
      return best;
   endfunction

   // serve jobs up to a tick, or until empty when draining
   task automatic serve_until(logic [39:0] limit, bit drain);
      int j;
      logic [39:0] run_ticks, flow;
      logic [63:0] sq;
      logic [40:0] t;
      rsp_type r;
      forever begin
         j = shortest_job();
         if (j < 0) begin
            if (!drain && sched_now < limit) sched_now = limit;
            return;
         end
         if (!drain && sched_now >= limit) return;
         run_ticks = {20'd0, job_left[j]};
         if (!drain && limit - sched_now < run_ticks) run_ticks = limit - sched_now;
         t = {1'b0, sched_now} + {1'b0, run_ticks};
         sched_now = t[40] ? TICK_MAX : t[39:0];
         job_left[j] = job_left[j] - run_ticks[19:0];
         if (job_left[j] != 0) continue;
         job_live[j] = 1'b0;
         flow = sched_now - {8'd0, job_arr[j]};
         run_flow_sum = sat_sum(run_flow_sum, {24'd0, flow});
         sq = (flow > 40'hFFFF_FFFF) ? '1 : 64'(flow) * 64'(flow);
         run_flow_sq = sat_sum(run_flow_sq, sq);
         if (flow > run_flow_max) run_flow_max = flow;
         if (run_jobs != '1) run_jobs++;
         r = '0;
         r.done_id = job_tag[j];
         r.finish_tick = sched_now;
         r.flow_time = flow;
         pending_records.insert(pending_records.size(), r);
      end
   endtask

   task automatic predict_item(req_type it);
      int free_slot, before_n;
      rsp_type r;
      before_n = pending_records.size();
      if (it.command == CMD_ARRIVAL) begin
         serve_until({8'd0, it.arrive_tick}, 1'b0);
         if (it.work_ticks != 0) begin
            free_slot = -1;
            for (int i = 0; i < STORE_N; i++)
               if (!job_live[i] && free_slot < 0) free_slot = i;
            if (free_slot < 0) begin
               run_dropped = 1'b1;
               r = '0;
               r.done_id = it.job_id;
               r.overflow = 1'b1;
               pending_records.insert(pending_records.size(), r);
            end else begin
               job_live[free_slot] = 1'b1;
               job_left[free_slot] = it.work_ticks;
               job_arr[free_slot] = it.arrive_tick;
               job_tag[free_slot] = it.job_id;
            end
         end
      end else begin
         serve_until('0, 1'b1);
         r = '0;
         r.is_summary = 1'b1;
         r.finish_tick = sched_now;
         r.flow_sum = run_flow_sum;
         r.flow_square_sum = run_flow_sq;
         r.flow_max = run_flow_max;
         r.jobs_done = run_jobs;
         r.overflow = run_dropped;
         pending_records.insert(pending_records.size(), r);
         sched_now = 0; run_flow_sum = 0; run_flow_sq = 0;
         run_flow_max = 0; run_jobs = 0; run_dropped = 1'b0;
      end
      if (pending_records.size() > before_n)
         pending_records[pending_records.size() - 1].last = 1'b1;
   endtask

   // offer one item and wait for acceptance; valid drops only when idling
   task automatic send_item(req_type it);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_item(it);
   endtask

   task automatic send_arrival(logic [31:0] at, logic [19:0] sz, logic [15:0] id);
      req_type it;
      it = '0;
      it.command = CMD_ARRIVAL;
      it.arrive_tick = at;
      it.work_ticks = sz;
      it.job_id = id;
      if (at > last_arrival) last_arrival = at;
      send_item(it);
   endtask

   task automatic send_finish();
      req_type it;
      it = '0;
      it.command = CMD_FINISH;
      it.arrive_tick = $urandom;
      it.work_ticks = 20'($urandom);
      it.job_id = 16'($urandom);
      last_arrival = 0;
      send_item(it);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   // compare each accepted record with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_records.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected record %p", rsp_data);
         end else begin
            e = pending_records.pop_front();
            if (rsp_data !== e) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", e, rsp_data);
            end
         end
      end
   end

   task automatic test_directed();
      send_finish();                          // empty finish
      send_arrival(32'd10, 20'd1, 16'd5);     // idle server jump
      send_arrival(32'd10, 20'd3, 16'd2);
      send_arrival(32'd10, 20'd3, 16'd1);     // tie on id
      send_arrival(32'd11, 20'd3, 16'd1);     // duplicate id
      send_arrival(32'd11, 20'd0, 16'd9);     // zero size
      send_arrival(32'd5, 20'd2, 16'd7);      // arrival in the past
      send_arrival(32'd12, 20'hFFFFF, 16'hFFFF);
      send_finish();
      // fill the store and overflow it
      for (int i = 0; i < 34; i++)
         send_arrival(32'hFFFF_FFF0, 20'hFFFFF, 16'(i));
      send_finish();                          // large flows, dropped flag
      wait_drained();
   endtask

   task automatic test_random(int n_items);
      logic [31:0] at;
      for (int k = 0; k < n_items; k++) begin
         if ($urandom_range(19, 0) == 0) send_finish();
         else if ($urandom_range(9, 0) == 0)
            send_arrival($urandom, 20'($urandom), 16'($urandom));   // noise
         else begin
            at = last_arrival + $urandom_range(40, 0);
            send_arrival(at, 20'($urandom_range(30, 0)), 16'($urandom));
         end
      end
      send_finish();
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_off_cycles = 3000;
      for (int i = 0; i < 12; i++)
         send_arrival(last_arrival + 1, 20'd1, 16'(i));
      send_finish();
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(12);
      send_idle_pct = 65;
      test_random(12);
      send_idle_pct = 0; recv_stall_pct = 65;
      test_random(12);
      send_idle_pct = 19; recv_stall_pct = 19;
      test_random(12);
      send_idle_pct = 0; recv_stall_pct = 0;
      test_backpressure();
      if (mismatch_count == 0 && pending_records.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
sv/srpt_pkg.sv
sv/srpt_ram.sv
sv/srpt_preemptive_scheduler_top.sv
test/tb_srpt_preemptive_scheduler_top.sv
